/* design/mvt_pkg.sv */
// Shared types, constants and word conversions for the 4x4 matrix-vector transform.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package mvt_pkg;

   localparam int WORD_WIDTH        = 32;
   localparam int FIELD_WIDTH       = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int ROW_WORDS         = 4;
   localparam int LANES             = 4;
   localparam int EXT_WIDTH         = 64;

   localparam logic [1:0] ACTION_SET_ROW   = 2'd0;
   localparam logic [1:0] ACTION_TRANSFORM = 2'd1;
   localparam logic [1:0] ACTION_NORMAL    = 2'd2;

   typedef logic signed [WORD_WIDTH-1:0]  word_type;
   typedef logic signed [FIELD_WIDTH-1:0] field_type;
   typedef logic [ROW_WORDS-1:0][WORD_WIDTH-1:0] row_type;

   typedef struct packed {
      logic prod_load;
      logic sum_load;
   } stage_ctrl_type;

   // Sign-extend a port field, then cut it to the storage word.
   function automatic word_type field_to_word(input field_type f);
      logic signed [EXT_WIDTH-1:0] ext;
      ext = EXT_WIDTH'(f);
      return ext[WORD_WIDTH-1:0];
   endfunction

   // Sign-extend a storage word, then cut it to the port field.
   function automatic field_type word_to_field(input word_type w);
      logic signed [EXT_WIDTH-1:0] ext;
      ext = EXT_WIDTH'(w);
      return ext[FIELD_WIDTH-1:0];
   endfunction

endpackage

/* design/mvt_channels.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on mvt_pkg for the field widths.
`timescale 1ns / 1ps

interface mvt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             action;
   logic [1:0]                             row_index;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] in_x;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] in_y;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] in_z;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] in_w;

   modport source (output valid, action, row_index, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, action, row_index, in_x, in_y, in_z, in_w, output ready);
endinterface

interface mvt_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] out_x;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] out_y;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] out_z;
   logic signed [mvt_pkg::FIELD_WIDTH-1:0] out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

/* design/mvt_lane.sv */
// One row lane: four multipliers into a product register, then a wrapped dot-product sum.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_lane #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  mvt_pkg::stage_ctrl_type ctrl,
   input  mvt_pkg::row_type        row_words,
   input  mvt_pkg::row_type        vec_words,
   output mvt_pkg::word_type       dot
);

   localparam int PW = 2 * mvt_pkg::WORD_WIDTH;

   logic signed [PW-1:0] prod_ff [mvt_pkg::ROW_WORDS];
   logic signed [PW-1:0] prod_in [mvt_pkg::ROW_WORDS];
   mvt_pkg::word_type    dot_ff;
   mvt_pkg::word_type    dot_in;

   // Sign-extend both words to the product width; each multiplier stays one word by one word.
   always_comb begin
      for (int j = 0; j < mvt_pkg::ROW_WORDS; j++) begin
         prod_in[j] = PW'($signed(row_words[j])) * PW'($signed(vec_words[j]));
      end
   end

   // Truncate each product toward minus infinity, keep one word, wrap the sum.
   always_comb begin : sum_blk
      logic signed [PW-1:0] shifted;
      mvt_pkg::word_type    acc;
      acc     = '0;
      shifted = '0;
      for (int j = 0; j < mvt_pkg::ROW_WORDS; j++) begin
         shifted = prod_ff[j] >>> FRAC_BITS;
         acc     = acc + shifted[mvt_pkg::WORD_WIDTH-1:0];
      end
      dot_in = acc;
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_load) begin
         prod_ff <= prod_in;
      end
      if (ctrl.sum_load) begin
         dot_ff <= dot_in;
      end
   end

   assign dot = dot_ff;

endmodule

/* design/mvt_merge.sv */
// Merge stage: gathers the four lane sums into one response beat and holds it until taken.
// Depends on mvt_pkg and mvt_channels.
`timescale 1ns / 1ps

module mvt_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   normal,
   input  mvt_pkg::word_type      lane_dot [mvt_pkg::LANES],
   output logic                   out_ready,
   mvt_rsp_if.source              rsp
);

   logic                 valid_ff;
   logic                 valid_in;
   mvt_pkg::field_type   x_ff, y_ff, z_ff, w_ff;

   assign out_ready = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Drop the fourth row for normals.
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= mvt_pkg::word_to_field(lane_dot[0]);
         y_ff <= mvt_pkg::word_to_field(lane_dot[1]);
         z_ff <= mvt_pkg::word_to_field(lane_dot[2]);
         w_ff <= normal ? '0 : mvt_pkg::word_to_field(lane_dot[3]);
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.out_x = x_ff;
   assign rsp.out_y = y_ff;
   assign rsp.out_z = z_ff;
   assign rsp.out_w = w_ff;

endmodule

/* design/matrix_vector_transform_4x4_core.sv */
// Top level of the 4x4 fixed-point matrix-vector transform: matrix store, four row lanes,
// merge stage and the pipeline handshake. Depends on mvt_pkg, mvt_channels, mvt_lane, mvt_merge.
`timescale 1ns / 1ps

//  channel | dir | beat carries                              | handshake
//  --------+-----+-------------------------------------------+-----------------------
//  req     | in  | action, row_index, in_x, in_y, in_z, in_w | valid/ready, req.*
//  rsp     | out | out_x, out_y, out_z, out_w                | valid/ready, rsp.*
//
//  Throughput: one request beat per cycle while req.ready stays high, set-row and vector beats alike.
//  Path: an accepted vector beat passes the product register, the lane sum register
//  and the merge output register on its way to rsp. The sixteen multipliers
//  in the four lanes set the first stage.
//  A set-row beat updates the matrix at its accept edge; the next beat sees it.
//  Reset (synchronous) loads the identity matrix and empties the pipeline.
//  Each stage advances when the one after it is empty or moving, so rsp stalls only
//  hold req once all three stages are full.

module matrix_vector_transform_4x4_core #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   mvt_req_if.sink   req,
   mvt_rsp_if.source rsp
);

   localparam mvt_pkg::word_type ONE_WORD = mvt_pkg::word_type'(1) << FRAC_BITS;

   // Matrix rows, each read at a fixed place by its own lane.
   mvt_pkg::row_type matrix_ff [mvt_pkg::ROW_WORDS];

   // Stage valids and the normal flag that rides along.
   logic s1_valid_ff, s1_valid_in;
   logic s1_normal_ff, s1_normal_in;
   logic s2_valid_ff, s2_valid_in;
   logic s2_normal_ff, s2_normal_in;

   logic s1_ready, s2_ready, out_ready;
   logic accept, is_vector, is_normal;

   mvt_pkg::stage_ctrl_type ctrl;
   mvt_pkg::row_type        vec_words;
   mvt_pkg::word_type       lane_dot [mvt_pkg::LANES];

   // ---------------------------------------------------------------------
   // Handshake: ready ripples back from the merge stage.
   // ---------------------------------------------------------------------
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready && !reset;
   assign accept    = req.valid && req.ready;

   assign is_normal = (req.action == mvt_pkg::ACTION_NORMAL);
   assign is_vector = (req.action == mvt_pkg::ACTION_TRANSFORM) || is_normal;

   // Product registers load with every accepted vector; sums advance with stage 1.
   assign ctrl.prod_load = accept && is_vector;
   assign ctrl.sum_load  = s1_valid_ff && s2_ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_normal_in = s1_normal_ff;
      s2_valid_in  = s2_valid_ff;
      s2_normal_in = s2_normal_ff;
      if (s1_ready) begin
         s1_valid_in  = accept && is_vector;
         s1_normal_in = is_normal;
      end
      if (s2_ready) begin
         s2_valid_in  = s1_valid_ff;
         s2_normal_in = s1_normal_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_normal_ff <= s1_normal_in;
      s2_normal_ff <= s2_normal_in;
   end

   // ---------------------------------------------------------------------
   // Matrix store: identity after reset, one row written per set-row beat.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mvt_pkg::ROW_WORDS; r++) begin
            for (int c = 0; c < mvt_pkg::ROW_WORDS; c++) begin
               matrix_ff[r][c] <= (r == c) ? ONE_WORD : '0;
            end
         end
      end else if (accept && req.action == mvt_pkg::ACTION_SET_ROW) begin
         matrix_ff[req.row_index][0] <= mvt_pkg::field_to_word(req.in_x);
         matrix_ff[req.row_index][1] <= mvt_pkg::field_to_word(req.in_y);
         matrix_ff[req.row_index][2] <= mvt_pkg::field_to_word(req.in_z);
         matrix_ff[req.row_index][3] <= mvt_pkg::field_to_word(req.in_w);
      end
   end

   // Normals ignore w: force it to zero so the fourth product of every row drops out.
   always_comb begin
      vec_words[0] = mvt_pkg::field_to_word(req.in_x);
      vec_words[1] = mvt_pkg::field_to_word(req.in_y);
      vec_words[2] = mvt_pkg::field_to_word(req.in_z);
      vec_words[3] = is_normal ? '0 : mvt_pkg::field_to_word(req.in_w);
   end

   // ---------------------------------------------------------------------
   // Four lanes, one per matrix row.
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < mvt_pkg::LANES; g++) begin : g_lane
      mvt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock     (clock),
         .ctrl      (ctrl),
         .row_words (matrix_ff[g]),
         .vec_words (vec_words),
         .dot       (lane_dot[g])
      );
   end

   // ---------------------------------------------------------------------
   // Merge lanes into the response beat.
   // ---------------------------------------------------------------------
   mvt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (s2_valid_ff && out_ready),
      .normal    (s2_normal_ff),
      .lane_dot  (lane_dot),
      .out_ready (out_ready),
      .rsp       (rsp)
   );

endmodule

/* design/mvt_checker.sv */
// Port-level checker for the 4x4 transform core, attached to the top level by bind.
// Depends on mvt_pkg and on the top level's ports.
`timescale 1ns / 1ps

module mvt_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [1:0]               req_action,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input mvt_pkg::field_type       rsp_out_x,
   input mvt_pkg::field_type       rsp_out_y,
   input mvt_pkg::field_type       rsp_out_z,
   input mvt_pkg::field_type       rsp_out_w
);

   logic [2:0] pending_ff, pending_in;
   logic       vec_beat, rsp_beat;

   assign vec_beat = req_valid && req_ready &&
                     (req_action == mvt_pkg::ACTION_TRANSFORM ||
                      req_action == mvt_pkg::ACTION_NORMAL);
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (vec_beat && !rsp_beat) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_beat && !vec_beat) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_z) && $stable(rsp_out_w))
      else $error("response beat changed while stalled");

   // No response without an outstanding vector beat.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response beat without a pending vector");

   // Three pipeline slots at most.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more vectors in flight than pipeline slots");

   // With the consumer ready, a vector beat shows on rsp without being held in the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(reset, 2) && rsp_ready && $past(rsp_ready) && $past(vec_beat, 2)
      |=> rsp_valid)
      else $error("vector beat did not reach the response in time");

endmodule

bind matrix_vector_transform_4x4_core mvt_checker u_mvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .req_action (req.action),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_out_x  (rsp.out_x),
   .rsp_out_y  (rsp.out_y),
   .rsp_out_z  (rsp.out_z),
   .rsp_out_w  (rsp.out_w)
);

/* dv/mvt_transform_checker.sv */
// Watches the request and response channels of the 4x4 matrix-vector transform,
// predicts each response beat from its own copy of the matrix and compares field by field.
// Depends on mvt_pkg and the channel interfaces in mvt_channels.
`timescale 1ns / 1ps

module mvt_transform_checker #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mvt_req_if   req,
   mvt_rsp_if   rsp,
   output int   failures,
   output int   pending
);

   typedef struct {
      mvt_pkg::word_type x;
      mvt_pkg::word_type y;
      mvt_pkg::word_type z;
      mvt_pkg::word_type w;
   } vec4_type;

   mvt_pkg::word_type coeff [0:3][0:3];
   vec4_type expected_vec_q [$];

   // Full signed product, arithmetic shift by the fraction bits, cut to a word.
   function automatic mvt_pkg::word_type fixed_mul(input mvt_pkg::word_type a,
                                                   input mvt_pkg::word_type b);
      logic signed [63:0] prod;
      prod = 64'(a) * 64'(b);
      prod = prod >>> FRAC_BITS;
      return mvt_pkg::word_type'(prod[mvt_pkg::WORD_WIDTH-1:0]);
   endfunction

   function automatic mvt_pkg::word_type row_dot(input int r, input mvt_pkg::word_type v [0:3],
                                                 input int terms);
      mvt_pkg::word_type acc;
      acc = '0;
      for (int j = 0; j < terms; j++)
         acc = acc + fixed_mul(coeff[r][j], v[j]);
      return acc;
   endfunction

   task automatic compare_field(input string name, input mvt_pkg::word_type want,
                                input mvt_pkg::word_type got);
      if (got !== want) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      vec4_type want;
      mvt_pkg::word_type v [0:3];
      if (reset) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               coeff[r][c] = (r == c) ? mvt_pkg::word_type'(64'sd1 << FRAC_BITS) : '0;
         expected_vec_q.delete();
      end else begin
         // Retire the response beat first; a request on this edge cannot produce it.
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_vec_q.size() == 0) begin
               failures++;
               $display("%0t ns: unexpected response beat, expected none, actual %h %h %h %h",
                        $time, rsp.out_x, rsp.out_y, rsp.out_z, rsp.out_w);
            end else begin
               want = expected_vec_q.pop_front();
               compare_field("out_x", want.x, rsp.out_x);
               compare_field("out_y", want.y, rsp.out_y);
               compare_field("out_z", want.z, rsp.out_z);
               compare_field("out_w", want.w, rsp.out_w);
            end
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            v[0] = req.in_x;
            v[1] = req.in_y;
            v[2] = req.in_z;
            v[3] = req.in_w;
            case (req.action)
               mvt_pkg::ACTION_SET_ROW: begin
                  for (int j = 0; j < 4; j++)
                     coeff[req.row_index][j] = v[j];
               end
               mvt_pkg::ACTION_TRANSFORM: begin
                  want.x = row_dot(0, v, 4);
                  want.y = row_dot(1, v, 4);
                  want.z = row_dot(2, v, 4);
                  want.w = row_dot(3, v, 4);
                  expected_vec_q.push_back(want);
               end
               mvt_pkg::ACTION_NORMAL: begin
                  want.x = row_dot(0, v, 3);
                  want.y = row_dot(1, v, 3);
                  want.z = row_dot(2, v, 3);
                  want.w = '0;
                  expected_vec_q.push_back(want);
               end
               default: ;
            endcase
         end
      end
      pending = expected_vec_q.size();
   end

endmodule

/* dv/tb_matrix_vector_transform_4x4_core.sv */
// Testbench top for the 4x4 matrix-vector transform: clock, reset, request stimulus and
// response back-pressure, with mvt_transform_checker beside the block for prediction.
// Depends on mvt_pkg, mvt_channels, the block's RTL and dv/mvt_transform_checker.sv.
`timescale 1ns / 1ps

module tb_matrix_vector_transform_4x4_core;

   // Action code the block must ignore: no matrix change, no response.
   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 450;
   // Three register stages to the response port, plus margin.
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   // Set while both sides run without idle cycles.
   bit   no_idle;

   mvt_req_if req_ch ();
   mvt_rsp_if rsp_ch ();

   matrix_vector_transform_4x4_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   mvt_transform_checker scoreboard (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .failures (failures),
      .pending  (pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Give up long after the slowest legal run would have finished.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Response side: stall a random number of cycles per beat, then hold ready
   // high until a beat is taken. Ready moves only on falling edges.
   initial begin : rsp_drain
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Offer one request beat after a random gap and hold it until accepted.
   // Valid is lowered only during a gap, so back-to-back beats keep it high.
   task automatic push_request(input logic [1:0] act, input logic [1:0] row,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.row_index <= row;
      req_ch.in_x      <= x;
      req_ch.in_y      <= y;
      req_ch.in_z      <= z;
      req_ch.in_w      <= w;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Drop valid and hold off until every predicted response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Small Q16.16 values half the time so sums stay readable, with extremes and raw words mixed in.
   function automatic logic [31:0] pick_component();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3, 4: return $urandom;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   initial begin : stimulus
      int sel;
      logic [1:0] act;
      reset            = 1'b1;
      no_idle          = 1'b0;
      req_ch.valid     = 1'b0;
      req_ch.action    = mvt_pkg::ACTION_SET_ROW;
      req_ch.row_index = 2'd0;
      req_ch.in_x      = '0;
      req_ch.in_y      = '0;
      req_ch.in_z      = '0;
      req_ch.in_w      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: identity matrix straight out of reset.
      push_request(mvt_pkg::ACTION_TRANSFORM, 2'd0, 32'h0001_0000, 32'h0002_0000,
                   32'hfffd_0000, 32'h0000_8000);
      push_request(mvt_pkg::ACTION_TRANSFORM, 2'd3, 32'h7fff_ffff, 32'h8000_0000,
                   32'hffff_ffff, 32'h0000_0000);
      // Normal beat: row index and w must not matter.
      push_request(mvt_pkg::ACTION_NORMAL, 2'd3, 32'h7fff_ffff, 32'h8000_0000,
                   32'h0000_0001, 32'h7fff_ffff);
      // Unused action must leave the matrix alone and return nothing.
      push_request(ACTION_UNUSED, 2'd2, 32'h1234_5678, 32'h8000_0000,
                   32'h7fff_ffff, 32'hdead_beef);
      push_request(mvt_pkg::ACTION_TRANSFORM, 2'd1, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 32'h0001_0000);
      // Load extreme rows, then push products and sums into wraparound.
      push_request(mvt_pkg::ACTION_SET_ROW, 2'd0, 32'h7fff_ffff, 32'h8000_0000,
                   32'h0000_0000, 32'hffff_ffff);
      push_request(mvt_pkg::ACTION_SET_ROW, 2'd1, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
      push_request(mvt_pkg::ACTION_SET_ROW, 2'd2, 32'h0002_0000, 32'hffff_0000,
                   32'h0000_8000, 32'h0000_0000);
      push_request(mvt_pkg::ACTION_SET_ROW, 2'd3, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 32'h0001_0000);
      push_request(mvt_pkg::ACTION_TRANSFORM, 2'd0, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
      push_request(mvt_pkg::ACTION_TRANSFORM, 2'd2, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff);
      push_request(mvt_pkg::ACTION_NORMAL, 2'd1, 32'h7fff_ffff, 32'h8000_0000,
                   32'h0000_0001, 32'h8000_0000);
      // Tiny negative products truncate toward minus infinity.
      push_request(mvt_pkg::ACTION_TRANSFORM, 2'd0, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 32'hffff_ffff);
      push_request(mvt_pkg::ACTION_NORMAL, 2'd0, 32'h0000_0001, 32'h0000_0001,
                   32'h0000_0001, 32'h0000_0001);
      // Back-to-back row write and use: the next beat must see the new row.
      no_idle = 1'b1;
      push_request(mvt_pkg::ACTION_SET_ROW, 2'd3, 32'h0000_0000, 32'h0000_0000,
                   32'h0000_0000, 32'h8000_0000);
      push_request(mvt_pkg::ACTION_TRANSFORM, 2'd0, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 32'h0003_0000);
      push_request(mvt_pkg::ACTION_SET_ROW, 2'd0, 32'h0001_0000, 32'h0000_0000,
                   32'h0000_0000, 32'h0000_0000);
      push_request(mvt_pkg::ACTION_NORMAL, 2'd2, 32'h0000_8000, 32'hffff_8000,
                   32'h0001_0000, 32'hffff_ffff);
      no_idle = 1'b0;
      wait_drained();

      // Random: mostly vector beats over a matrix that keeps changing.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_BEATS / 2)
            wait_drained();
         sel = $urandom_range(0, 19);
         if (sel < 5)
            act = mvt_pkg::ACTION_SET_ROW;
         else if (sel < 12)
            act = mvt_pkg::ACTION_TRANSFORM;
         else if (sel < 19)
            act = mvt_pkg::ACTION_NORMAL;
         else
            act = ACTION_UNUSED;
         push_request(act, 2'($urandom_range(0, 3)), pick_component(), pick_component(),
                      pick_component(), pick_component());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
design/mvt_pkg.sv
design/mvt_channels.sv
design/mvt_lane.sv
design/mvt_merge.sv
design/matrix_vector_transform_4x4_core.sv
design/mvt_checker.sv
dv/mvt_transform_checker.sv
dv/tb_matrix_vector_transform_4x4_core.sv
